FILE: src/itrd_pkg.sv
// Shared types, constants and helpers for the integer to radix digits block.
`default_nettype none

package itrd_pkg;

   // Dividend bits consumed per cycle by the shared divide unit.
   localparam int unsigned STEP_BITS = 4;
   // Bits of one digit; the radix never exceeds sixteen.
   localparam int unsigned DIGIT_W   = 4;
   localparam int unsigned RADIX_W   = 5;
   localparam int unsigned SYMBOL_W  = 8;

   // Configuration port geometry: 64-bit registers at byte address 8*i.
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHABET_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHABET_HIGH = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FETCH,
      ST_LOAD,
      ST_ZERO
   } state_type;

   // Pick the alphabet byte for one digit value.
   function automatic logic [SYMBOL_W-1:0] symbol_of(
      input logic [CSR_DATA_W-1:0] alpha_low,
      input logic [CSR_DATA_W-1:0] alpha_high,
      input logic [DIGIT_W-1:0]    digit
   );
      logic [5:0] ofs;
      ofs = {digit[2:0], 3'b000};
      if (digit[3]) begin
         return alpha_high[ofs +: SYMBOL_W];
      end
      return alpha_low[ofs +: SYMBOL_W];
   endfunction

endpackage

`default_nettype wire

FILE: src/itrd_if.sv
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface itrd_req_if #(
   parameter int unsigned VALUE_WIDTH = 31
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface itrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       is_last;
   logic       is_empty;

   modport source (output valid, output symbol, output is_last, output is_empty, input ready);
   modport sink   (input valid, input symbol, input is_last, input is_empty, output ready);
endinterface

`default_nettype wire

FILE: src/integer_to_radix_digits.sv
// Top level: converts an unsigned integer into alphabet characters in a configured radix.
//
// Usage:
//  - req_bus carries one value per transfer; rsp_bus returns its digits, most significant
//    first, one character per transfer, with is_last on the final one. A zero value
//    returns one transfer with symbol 0 and both is_last and is_empty set.
//  - The csr_ port holds radix (byte address 0), alphabet_low (8) and alphabet_high (16);
//    write them only while no conversion is in flight. Radix saturates to 2..MAX_RADIX.
//  - Each digit comes from repeated steps of the shared 4-bit-per-cycle divide unit;
//    once every digit is stored, each is read back from the digit store and loaded
//    into the output register.
//  - req_bus.ready is high only between items; the next value is taken while the last
//    character still waits in the output register.
//  - A stalled receiver holds the output register and the sequencer waits for it.
//  - Reset clears the sequencer and output valid and restores radix 10 and a zero
//    alphabet; the digit store needs no clearing since it is written before it is read.
`default_nettype none

module integer_to_radix_digits #(
   parameter int unsigned MAX_DIGITS  = 31,
   parameter int unsigned MAX_RADIX   = 16,
   parameter int unsigned VALUE_WIDTH = 31
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   itrd_req_if.sink                                 req_bus,
   itrd_rsp_if.source                               rsp_bus,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [itrd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [itrd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [itrd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);
   import itrd_pkg::*;

   // Dividend padded to whole division steps.
   localparam int unsigned QW    = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
   localparam int unsigned NSTEP = QW / STEP_BITS;
   localparam int unsigned SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
   localparam int unsigned AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int unsigned CW    = $clog2(MAX_DIGITS + 1);

   localparam logic [SW-1:0]      LAST_STEP   = SW'(NSTEP - 1);
   localparam logic [CW-1:0]      LAST_DIGIT  = CW'(MAX_DIGITS - 1);
   localparam logic [RADIX_W-1:0] RADIX_LIMIT = RADIX_W'(MAX_RADIX);

   // ---------------------------------------------------------------- configuration
   logic [RADIX_W-1:0]    radix_ff,  radix_in;
   logic [CSR_DATA_W-1:0] alpha_lo_ff, alpha_lo_in;
   logic [CSR_DATA_W-1:0] alpha_hi_ff, alpha_hi_in;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic                  csr_write;
   logic [RADIX_W-1:0]    radix_eff;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1 -: CSR_IDX_W];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      radix_in    = radix_ff;
      alpha_lo_in = alpha_lo_ff;
      alpha_hi_in = alpha_hi_ff;
      if (csr_write) begin
         unique case (csr_idx)
            CSR_RADIX:         radix_in    = csr_pwdata[RADIX_W-1:0];
            CSR_ALPHABET_LOW:  alpha_lo_in = csr_pwdata;
            CSR_ALPHABET_HIGH: alpha_hi_in = csr_pwdata;
            default:           ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_RADIX:         csr_prdata = CSR_DATA_W'(radix_ff);
         CSR_ALPHABET_LOW:  csr_prdata = alpha_lo_ff;
         CSR_ALPHABET_HIGH: csr_prdata = alpha_hi_ff;
         default:           csr_prdata = '0;
      endcase
   end

   // Clamp the radix into the range the divide unit supports.
   always_comb begin
      priority if (radix_ff < RADIX_MIN) begin
         radix_eff = RADIX_MIN;
      end else if (radix_ff > RADIX_LIMIT) begin
         radix_eff = RADIX_LIMIT;
      end else begin
         radix_eff = radix_ff;
      end
   end

   // ---------------------------------------------------------------- sequencer state
   state_type              state_ff, state_in;
   logic [QW-1:0]          quot_ff, quot_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [DIGIT_W-1:0]     rd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0]    rsp_symbol_ff, rsp_symbol_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   logic                   req_accept;
   logic                   out_free;
   logic                   step_done;
   logic                   div_stop;
   logic                   rsp_load;
   logic                   wr_en;
   logic [DIGIT_W-1:0]     div_rem;
   logic [STEP_BITS-1:0]   div_quo;
   logic [QW-1:0]          quot_shift;

   logic [DIGIT_W-1:0]     digit_mem [MAX_DIGITS];

   // Hold ready low during reset so no transfer is taken and then dropped.
   assign req_bus.ready = (state_ff == ST_IDLE) && !reset;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Shared divide unit: top dividend bits in, quotient bits shifted in below.
   itrd_div_step u_div_step (
      .rem_i   (rem_ff),
      .bits_i  (quot_ff[QW-1 -: STEP_BITS]),
      .radix_i (radix_eff),
      .rem_o   (div_rem),
      .quo_o   (div_quo)
   );

   assign quot_shift = (quot_ff << STEP_BITS) | QW'(div_quo);
   assign step_done  = (step_ff == LAST_STEP);
   assign div_stop   = (quot_shift == '0) || (count_ff == LAST_DIGIT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_bus.value == '0) ? ST_ZERO : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (step_done && div_stop) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = (rd_ptr_ff == '0) ? ST_IDLE : ST_FETCH;
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and output register controls.
   always_comb begin
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_en         = 1'b0;
      rsp_load      = 1'b0;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               quot_in  = QW'(req_bus.value);
               rem_in   = '0;
               step_in  = '0;
               count_in = '0;
            end
         end
         ST_DIVIDE: begin
            quot_in = quot_shift;
            if (step_done) begin
               // Store the finished digit and restart the remainder for the next one.
               wr_en     = 1'b1;
               rem_in    = '0;
               step_in   = '0;
               count_in  = CW'(count_ff + 1'b1);
               rd_ptr_in = count_ff[AW-1:0];
            end else begin
               rem_in  = div_rem;
               step_in = SW'(step_ff + 1'b1);
            end
         end
         ST_FETCH: ;
         ST_LOAD: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_symbol_in = symbol_of(alpha_lo_ff, alpha_hi_ff, rd_data_ff);
               rsp_last_in   = (rd_ptr_ff == '0);
               rsp_empty_in  = 1'b0;
               if (rd_ptr_ff != '0) begin
                  rd_ptr_in = AW'(rd_ptr_ff - 1'b1);
               end
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_symbol_in = '0;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = 1'b1;
            end
         end
         default: ;
      endcase
      // Hold valid until the receiver takes the transfer.
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Digit store: least significant digit at index zero, read back downward.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[count_ff[AW-1:0]] <= div_rem;
      end
      rd_data_ff <= digit_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         quot_ff      <= '0;
         radix_ff     <= RADIX_RESET;
         alpha_lo_ff  <= '0;
         alpha_hi_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         quot_ff      <= quot_in;
         radix_ff     <= radix_in;
         alpha_lo_ff  <= alpha_lo_in;
         alpha_hi_ff  <= alpha_hi_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      rd_ptr_ff     <= rd_ptr_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.symbol   = rsp_symbol_ff;
   assign rsp_bus.is_last  = rsp_last_ff;
   assign rsp_bus.is_empty = rsp_empty_ff;

endmodule

`default_nettype wire

FILE: src/itrd_div_step.sv
// Restoring division step: folds STEP_BITS dividend bits into a remainder below the radix.
`default_nettype none

module itrd_div_step (
   input  wire logic [itrd_pkg::DIGIT_W-1:0]   rem_i,
   input  wire logic [itrd_pkg::STEP_BITS-1:0] bits_i,
   input  wire logic [itrd_pkg::RADIX_W-1:0]   radix_i,
   output logic      [itrd_pkg::DIGIT_W-1:0]   rem_o,
   output logic      [itrd_pkg::STEP_BITS-1:0] quo_o
);
   import itrd_pkg::*;

   always_comb begin
      logic [DIGIT_W-1:0] rem;
      logic [DIGIT_W:0]   trial;
      rem   = rem_i;
      quo_o = '0;
      // Walk the bits most significant first; subtract where the radix fits.
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         trial = {rem, bits_i[i]};
         if (trial >= radix_i) begin
            rem      = DIGIT_W'(trial - radix_i);
            quo_o[i] = 1'b1;
         end else begin
            rem = trial[DIGIT_W-1:0];
         end
      end
      rem_o = rem;
   end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the integer to radix digits block.
module tb;
   import itrd_pkg::*;

   localparam int unsigned MAX_DIGITS  = 31;
   localparam int unsigned MAX_RADIX   = 16;
   localparam int unsigned VALUE_WIDTH = 31;
   localparam int          CLK_PERIOD  = 12;
   // Generous ceiling: far above the slowest legal run (full radix-2 values under
   // heavy receiver stall), so only a hang trips it.
   localparam int          TIMEOUT_CYCLES = 2_000_000;
   // Let the block settle past the longest single conversion.
   localparam int          TAIL_CYCLES    = 400;
   // Register slot past the end of the map; writes there must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One character transfer as it appears on the response channel.
   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                is_last;
      logic                is_empty;
   } digit_char_type;

   // Tracks the register shadow, predicts the characters of every accepted
   // value and compares them against what the block sends back.
   class digit_scoreboard_type;
      logic [RADIX_W-1:0]    radix_reg;
      logic [CSR_DATA_W-1:0] alpha_lo;
      logic [CSR_DATA_W-1:0] alpha_hi;
      digit_char_type        expected_chars[$];
      int                    failures;
      int                    values_noted;
      int                    zero_values;
      int                    chars_checked;

      function new();
         radix_reg     = RADIX_RESET;
         alpha_lo      = '0;
         alpha_hi      = '0;
         failures      = 0;
         values_noted  = 0;
         zero_values   = 0;
         chars_checked = 0;
      endfunction

      function void set_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
         unique case (idx)
            CSR_RADIX:         radix_reg = data[RADIX_W-1:0];
            CSR_ALPHABET_LOW:  alpha_lo  = data;
            CSR_ALPHABET_HIGH: alpha_hi  = data;
            default: ;
         endcase
      endfunction

      // Split a value into digits of the effective radix and queue the characters,
      // most significant first.
      function void note_value(input logic [VALUE_WIDTH-1:0] value);
         logic [DIGIT_W-1:0]     digits [MAX_DIGITS];
         logic [VALUE_WIDTH-1:0] quotient;
         logic [127:0]           alphabet;
         int unsigned            base;
         int unsigned            count;
         int unsigned            k;
         digit_char_type         c;
         values_noted++;
         if (value == '0) begin
            zero_values++;
            c.symbol   = '0;
            c.is_last  = 1'b1;
            c.is_empty = 1'b1;
            expected_chars.push_back(c);
            return;
         end
         base = (radix_reg < 2) ? 2 : (radix_reg > MAX_RADIX) ? MAX_RADIX : radix_reg;
         alphabet = {alpha_hi, alpha_lo};
         quotient = value;
         count    = 0;
         while (quotient != '0 && count < MAX_DIGITS) begin
            digits[count] = DIGIT_W'(quotient % base);
            quotient      = quotient / base;
            count++;
         end
         for (k = count; k > 0; k--) begin
            c.symbol   = alphabet[{digits[k-1], 3'b000} +: SYMBOL_W];
            c.is_last  = (k == 1);
            c.is_empty = 1'b0;
            expected_chars.push_back(c);
         end
      endfunction

      function void report(input string what);
         failures++;
         if (failures <= 10) $display("%s", what);
      endfunction

      function void check_char(input logic [SYMBOL_W-1:0] symbol,
                               input logic is_last, input logic is_empty);
         digit_char_type want;
         chars_checked++;
         if (expected_chars.size() == 0) begin
            report($sformatf("unexpected character: symbol %02h last %0b empty %0b",
                             symbol, is_last, is_empty));
            return;
         end
         want = expected_chars.pop_front();
         if (want.symbol !== symbol || want.is_last !== is_last ||
             want.is_empty !== is_empty)
            report($sformatf({"mismatch: expected symbol %02h last %0b empty %0b,",
                              " got symbol %02h last %0b empty %0b"},
                             want.symbol, want.is_last, want.is_empty,
                             symbol, is_last, is_empty));
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   wire  [CSR_DATA_W-1:0] csr_prdata;
   wire                   csr_pready;

   itrd_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_bus ();
   itrd_rsp_if                              rsp_bus ();

   digit_scoreboard_type sb = new;

   int send_idle_pct;
   int recv_stall_pct;
   int register_writes;

   integer_to_radix_digits #(
      .MAX_DIGITS (MAX_DIGITS),
      .MAX_RADIX  (MAX_RADIX),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      clock = 1'b0;
      #(CLK_PERIOD / 2);
      clock = 1'b1;
      #(CLK_PERIOD / 2);
   end

   // Receiver: re-roll ready every cycle so stalls land on every phase of the
   // sequencer, including while the last character of one value is held.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: note each input transfer before checking a result from the same edge,
   // so predictions are always queued ahead of the characters they describe.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_value(req_bus.value);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_char(rsp_bus.symbol, rsp_bus.is_last, rsp_bus.is_empty);
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      unique case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 78; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 78; end
         default:       begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
   endtask

   // Offer one value and hold it until the block takes it. Valid stays high on
   // return so a following value goes out back to back; idle gaps drop it.
   task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and hold off until every predicted character has been seen.
   // The first edge lets the monitor record a transfer from the current edge.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Two-phase register write: setup, then access until pready completes the transfer.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, data);
      register_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Radix goes out with random upper bits, which the block must ignore.
   task automatic configure(input logic [RADIX_W-1:0] radix,
                            input logic [CSR_DATA_W-1:0] lo,
                            input logic [CSR_DATA_W-1:0] hi);
      logic [CSR_DATA_W-1:0] word;
      word = {$urandom, $urandom};
      word[RADIX_W-1:0] = radix;
      csr_write(CSR_RADIX, word);
      csr_write(CSR_ALPHABET_LOW, lo);
      csr_write(CSR_ALPHABET_HIGH, hi);
   endtask

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("timeout with %0d characters outstanding", sb.pending());
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [RADIX_W-1:0]     radix;
      logic [CSR_DATA_W-1:0]  lo;
      logic [CSR_DATA_W-1:0]  hi;
      logic [VALUE_WIDTH-1:0] v;
      int                     w;
      req_bus.valid   = 1'b0;
      req_bus.value   = '0;
      rsp_bus.ready   = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      register_writes = 0;
      reset           = 1'b1;
      set_idling(IDLE_NONE);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: radix 10 with an all-zero alphabet.
      send_value('0);
      send_value(31'd1);
      send_value(31'h7FFF_FFFF);
      send_value(31'd1234567890);
      drain_results();

      // Hex alphabet, top radix: field extremes and alternating bit patterns.
      configure(5'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
      set_idling(IDLE_BOTH);
      send_value(31'h7FFF_FFFF);
      send_value(31'h2AAA_AAAA);
      send_value(31'h5555_5555);
      send_value(31'd15);
      send_value(31'd16);
      send_value('0);
      drain_results();

      // Radix 2: a full-width value gives the longest digit string.
      csr_write(CSR_RADIX, 64'd2);
      set_idling(IDLE_RECEIVER);
      send_value(31'h7FFF_FFFF);
      send_value(31'd1);
      send_value(31'h4000_0000);
      drain_results();

      // Out-of-range radix values saturate to the nearest legal base.
      set_idling(IDLE_SENDER);
      csr_write(CSR_RADIX, 64'd0);
      send_value(31'd5);
      drain_results();
      csr_write(CSR_RADIX, 64'd1);
      send_value(31'd6);
      drain_results();
      csr_write(CSR_RADIX, 64'd31);
      send_value(31'd255);
      drain_results();
      csr_write(CSR_RADIX, 64'd17);
      send_value(31'h7FFF_FFFF);
      drain_results();
      csr_write(CSR_RADIX, 64'd3);
      send_value(31'h7FFF_FFFF);
      drain_results();

      // A write past the register map must leave radix 3 in place.
      csr_write(CSR_UNUSED, 64'd7);
      send_value(31'd100);
      drain_results();

      // Random phases: new settings each time, idling style rotates so some
      // phases run flat out.
      for (int p = 0; p < 10; p++) begin
         unique case (p)
            0:       radix = 5'd2;
            1:       radix = 5'd16;
            default: radix = 5'($urandom_range(0, 31));
         endcase
         unique case (p)
            2:       begin lo = '1; hi = '1; end
            3:       begin lo = '0; hi = '0; end
            default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
         endcase
         configure(radix, lo, hi);
         set_idling(idle_mode_type'(p % 4));
         for (int n = 0; n < 25; n++) begin
            // Random bit length spreads values from zero up to full width.
            w = $urandom_range(0, VALUE_WIDTH);
            v = VALUE_WIDTH'($urandom & ((64'd1 << w) - 1));
            send_value(v);
            // Pause now and then until the block has emptied out.
            if (n == 12 || $urandom_range(29) == 0) drain_results();
         end
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("converted %0d values (%0d zero), checked %0d characters",
               sb.values_noted, sb.zero_values, sb.chars_checked);
      $display("over %0d register writes, radix extremes and saturation included",
               register_writes);
      if (sb.failures + sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d failures, %0d characters never arrived", sb.failures, sb.pending());
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/itrd_pkg.sv
src/itrd_if.sv
src/itrd_div_step.sv
src/integer_to_radix_digits.sv
sim/tb.sv
